// ===== hdl/running_median_two_heap_defines.svh =====
// assertion macros for the running median block
`ifndef RUNNING_MEDIAN_TWO_HEAP_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAP_DEFINES_SVH

`ifndef SYNTHESIS
// condition that must hold at every edge out of reset
`define RMTH_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("running median check failed");
// implication within the same edge
`define RMTH_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("running median check failed");
`else
`define RMTH_ASSERT_ALWAYS(label, cond)
`define RMTH_ASSERT_IMPLY(label, ante, cons)
`endif

`endif

// ===== hdl/rmth_pkg.sv =====
// shared types and constants for the running median block
`timescale 1ns / 1ps

package rmth_pkg;

  // fixed widths of the request and result fields
  localparam int SAMPLE_PORT_W = 32;
  localparam int MEDIAN_W      = 33;
  localparam int COUNT_W       = 11;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHECK,
    S_UP_CMP,
    S_AFTER_PUSH,
    S_POP0,
    S_POP1,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DN_MOVE,
    S_POP_DONE,
    S_EMIT
  } rmth_state_t;

  // which heap the shared datapath works on
  typedef enum logic {
    HEAP_LOWER,
    HEAP_UPPER
  } heap_sel_t;

  // insert of the new sample, or the second insert of a rebalance
  typedef enum logic {
    PH_INSERT,
    PH_REBAL
  } rmth_phase_t;

endpackage

// ===== hdl/running_median_two_heap.sv =====
// running median over two heaps, one compare unit under a small sequencer
// a full store rejects the request and goes straight to the result; an insert sifts the new
// sample up from the bottom of its heap; a rebalance pops the top of the larger heap, sifts the
// last entry down from the root and then inserts the popped top into the other heap
// one request at a time; the single read port of the heap ram reads one entry a cycle
// reset empties both heaps at once by clearing the sizes; ram contents are left as they are
`timescale 1ns / 1ps

`include "running_median_two_heap_defines.svh"

module running_median_two_heap
  import rmth_pkg::*;
#(
  parameter int CAPACITY     = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_PORT_W-1:0]   sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [MEDIAN_W-1:0] median_x2,
  output logic [COUNT_W-1:0]         stored_count,
  output logic                       accepted
);

  localparam int HALF_DEPTH = (CAPACITY + 1) / 2 + 1;
  localparam int AW         = $clog2(HALF_DEPTH);
  localparam int SIZE_W     = $clog2(HALF_DEPTH + 1);
  localparam int TOT_W      = SIZE_W + 1;
  localparam int CW         = AW + 2;
  localparam logic [TOT_W-1:0] CAP_T = TOT_W'(CAPACITY);

  typedef logic signed [SAMPLE_WIDTH-1:0] samp_t;

  rmth_state_t state, state_next;
  rmth_phase_t phase, phase_next;
  heap_sel_t   sel, sel_next;

  logic [SIZE_W-1:0] lower_size, lower_size_next;
  logic [SIZE_W-1:0] upper_size, upper_size_next;
  samp_t             lower_top, lower_top_next;
  samp_t             upper_top, upper_top_next;
  samp_t             v, v_next;
  samp_t             x, x_next;
  samp_t             bv, bv_next;
  logic [AW-1:0]     idx, idx_next;
  logic [AW-1:0]     best, best_next;
  logic              acc, acc_next;
  logic              out_valid_next;
  logic              load_out;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  samp_t         ram_wdata;
  logic [AW-1:0] ram_raddr;
  samp_t         lower_rdata, upper_rdata, rdata;

  // shared compare unit
  logic  cmp_max;
  samp_t cmp_a, cmp_b, cmp_lhs, cmp_rhs;
  logic  cmp_gt;

  samp_t             in_s;
  logic [SIZE_W-1:0] cur_size, cur_dec;
  logic [TOT_W-1:0]  total;
  logic              full;
  logic [AW-1:0]     idx_dec, parent;
  logic [CW-1:0]     left, right, cnt_ext;

  logic signed [MEDIAN_W-1:0]  lt_ext, ut_ext, med;
  logic [TOT_W+COUNT_W-1:0]    tot_ext;

  // heap stores
  rmth_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HALF_DEPTH)) u_lower_ram (
    .clk   (clk),
    .we    (ram_we && (sel == HEAP_LOWER)),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (lower_rdata)
  );

  rmth_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HALF_DEPTH)) u_upper_ram (
    .clk   (clk),
    .we    (ram_we && (sel == HEAP_UPPER)),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (upper_rdata)
  );

  assign rdata = (sel == HEAP_LOWER) ? lower_rdata : upper_rdata;

  // sample slice, sizes and index arithmetic
  assign in_s     = samp_t'(sample[SAMPLE_WIDTH-1:0]);
  assign cur_size = (sel == HEAP_LOWER) ? lower_size : upper_size;
  assign cur_dec  = cur_size - SIZE_W'(1);
  assign total    = TOT_W'(lower_size) + TOT_W'(upper_size);
  assign full     = (total >= CAP_T);
  assign idx_dec  = idx - AW'(1);
  assign parent   = idx_dec >> 1;
  assign left     = (CW'(idx) << 1) | CW'(1);
  assign right    = left + CW'(1);
  assign cnt_ext  = CW'(cur_size);

  // max-heap order on the lower heap, min-heap order on the upper heap
  assign cmp_lhs = cmp_max ? cmp_a : cmp_b;
  assign cmp_rhs = cmp_max ? cmp_b : cmp_a;
  assign cmp_gt  = (cmp_lhs > cmp_rhs);

  // twice the median from the cached heap tops
  assign lt_ext  = MEDIAN_W'(lower_top);
  assign ut_ext  = MEDIAN_W'(upper_top);
  assign tot_ext = {{COUNT_W{1'b0}}, total};

  always_comb begin
    if (lower_size > upper_size) begin
      med = lt_ext + lt_ext;
    end else if (lower_size != '0) begin
      med = lt_ext + ut_ext;
    end else begin
      med = '0;
    end
  end

  assign in_stall = (state != S_IDLE);

  // sequencer: next state, datapath and ram control
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    sel_next        = sel;
    lower_size_next = lower_size;
    upper_size_next = upper_size;
    lower_top_next  = lower_top;
    upper_top_next  = upper_top;
    v_next          = v;
    x_next          = x;
    bv_next         = bv;
    idx_next        = idx;
    best_next       = best;
    acc_next        = acc;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = v;
    ram_raddr       = '0;
    cmp_max         = (sel == HEAP_LOWER);
    cmp_a           = v;
    cmp_b           = rdata;
    load_out        = 1'b0;

    unique case (state)
      S_IDLE: begin
        // new sample goes low when the lower heap is empty or it is not above its top
        cmp_max = 1'b1;
        cmp_a   = in_s;
        cmp_b   = lower_top;
        if (in_valid) begin
          if (full) begin
            acc_next   = 1'b0;
            state_next = S_EMIT;
          end else begin
            acc_next   = 1'b1;
            v_next     = in_s;
            phase_next = PH_INSERT;
            if ((lower_size == '0) || !cmp_gt) begin
              sel_next        = HEAP_LOWER;
              idx_next        = lower_size[AW-1:0];
              lower_size_next = lower_size + SIZE_W'(1);
            end else begin
              sel_next        = HEAP_UPPER;
              idx_next        = upper_size[AW-1:0];
              upper_size_next = upper_size + SIZE_W'(1);
            end
            state_next = S_UP_CHECK;
          end
        end
      end

      S_UP_CHECK: begin
        // hole at the root takes the value, otherwise fetch the parent
        if (idx == '0) begin
          ram_we     = 1'b1;
          ram_waddr  = '0;
          ram_wdata  = v;
          state_next = S_AFTER_PUSH;
        end else begin
          ram_raddr  = parent;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmp_a = v;
        cmp_b = rdata;
        ram_we    = 1'b1;
        ram_waddr = idx;
        if (cmp_gt) begin
          ram_wdata  = rdata;
          idx_next   = parent;
          state_next = S_UP_CHECK;
        end else begin
          ram_wdata  = v;
          state_next = S_AFTER_PUSH;
        end
      end

      S_AFTER_PUSH: begin
        // rebalance so that the lower heap holds equal or one more
        if ((phase == PH_INSERT) &&
            (TOT_W'(lower_size) > TOT_W'(upper_size) + TOT_W'(1))) begin
          sel_next   = HEAP_LOWER;
          state_next = S_POP0;
        end else if ((phase == PH_INSERT) && (upper_size > lower_size)) begin
          sel_next   = HEAP_UPPER;
          state_next = S_POP0;
        end else begin
          state_next = S_EMIT;
        end
      end

      S_POP0: begin
        // keep the top for the other heap, fetch the last entry
        v_next    = (sel == HEAP_LOWER) ? lower_top : upper_top;
        ram_raddr = cur_dec[AW-1:0];
        if (sel == HEAP_LOWER) begin
          lower_size_next = cur_dec;
        end else begin
          upper_size_next = cur_dec;
        end
        state_next = S_POP1;
      end

      S_POP1: begin
        x_next     = rdata;
        idx_next   = '0;
        state_next = S_DN_L;
      end

      S_DN_L: begin
        if (left >= cnt_ext) begin
          ram_we     = 1'b1;
          ram_waddr  = idx;
          ram_wdata  = x;
          state_next = S_POP_DONE;
        end else begin
          ram_raddr  = left[AW-1:0];
          state_next = S_DN_R;
        end
      end

      S_DN_R: begin
        // left child against the sinking value
        cmp_a = rdata;
        cmp_b = x;
        if (cmp_gt) begin
          bv_next   = rdata;
          best_next = left[AW-1:0];
        end else begin
          bv_next   = x;
          best_next = idx;
        end
        if (right < cnt_ext) begin
          ram_raddr  = right[AW-1:0];
          state_next = S_DN_CMP;
        end else begin
          state_next = S_DN_MOVE;
        end
      end

      S_DN_CMP: begin
        // right child against the best so far
        cmp_a = rdata;
        cmp_b = bv;
        if (cmp_gt) begin
          bv_next   = rdata;
          best_next = right[AW-1:0];
        end
        state_next = S_DN_MOVE;
      end

      S_DN_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        if (best == idx) begin
          ram_wdata  = x;
          state_next = S_POP_DONE;
        end else begin
          ram_wdata  = bv;
          idx_next   = best;
          state_next = S_DN_L;
        end
      end

      S_POP_DONE: begin
        // push the popped top into the other heap
        phase_next = PH_REBAL;
        if (sel == HEAP_LOWER) begin
          sel_next        = HEAP_UPPER;
          idx_next        = upper_size[AW-1:0];
          upper_size_next = upper_size + SIZE_W'(1);
        end else begin
          sel_next        = HEAP_LOWER;
          idx_next        = lower_size[AW-1:0];
          lower_size_next = lower_size + SIZE_W'(1);
        end
        state_next = S_UP_CHECK;
      end

      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // cached tops follow every root write
    if (ram_we && (ram_waddr == '0)) begin
      if (sel == HEAP_LOWER) begin
        lower_top_next = ram_wdata;
      end else begin
        upper_top_next = ram_wdata;
      end
    end
  end

  // result register handshake
  always_comb begin
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_INSERT;
      sel        <= HEAP_LOWER;
      lower_size <= '0;
      upper_size <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      sel        <= sel_next;
      lower_size <= lower_size_next;
      upper_size <= upper_size_next;
      out_valid  <= out_valid_next;
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    lower_top <= lower_top_next;
    upper_top <= upper_top_next;
    v         <= v_next;
    x         <= x_next;
    bv        <= bv_next;
    idx       <= idx_next;
    best      <= best_next;
    acc       <= acc_next;
    if (load_out) begin
      median_x2    <= med;
      stored_count <= tot_ext[COUNT_W-1:0];
      accepted     <= acc;
    end
  end

  // checks
  `RMTH_ASSERT_ALWAYS(a_total_in_range, total <= CAP_T)
  `RMTH_ASSERT_IMPLY(a_balanced_idle, state == S_IDLE,
                     (lower_size == upper_size) ||
                     (TOT_W'(lower_size) == TOT_W'(upper_size) + TOT_W'(1)))
  `RMTH_ASSERT_IMPLY(a_pop_nonempty, state == S_POP0, cur_size != '0)
  `RMTH_ASSERT_IMPLY(a_reject_only_full, (state == S_EMIT) && !acc, total == CAP_T)

endmodule

// ===== hdl/rmth_ram.sv =====
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module rmth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 513
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/running_median_two_heap_tb.sv =====
// testbench for the two-heap running median block, checked against a sorted-store predictor
`timescale 1ns / 1ps

module running_median_two_heap_tb
  import rmth_pkg::*;
();

  localparam int CAPACITY     = 1024;
  localparam int RANDOM_ITEMS = 1430;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef logic signed [SAMPLE_PORT_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0]      median_t;

  typedef struct packed {
    median_t            median_x2;
    logic [COUNT_W-1:0] stored_count;
    logic               accepted;
  } median_result_t;

  // predicts each result from a sorted copy of the stored samples
  class median_scoreboard;
    sample_t        held_q[$];
    median_result_t due_q[$];
    int             capacity;
    int unsigned    fail_count;

    function new(int cap);
      capacity   = cap;
      fail_count = 0;
    endfunction

    // insert in order unless full, then work out twice the middle
    function void note_request(sample_t value);
      median_result_t r;
      median_t        lo;
      median_t        hi;
      int             pos;
      int             n;
      r.accepted = 1'b0;
      if (held_q.size() < capacity) begin
        pos = 0;
        while (pos < held_q.size() && held_q[pos] <= value) pos++;
        held_q.insert(pos, value);
        r.accepted = 1'b1;
      end
      n = held_q.size();
      if (n == 0) begin
        r.median_x2 = '0;
      end else if (n % 2 == 1) begin
        lo = held_q[(n - 1) / 2];
        r.median_x2 = lo + lo;
      end else begin
        lo = held_q[n / 2 - 1];
        hi = held_q[n / 2];
        r.median_x2 = lo + hi;
      end
      r.stored_count = COUNT_W'(n);
      due_q = {due_q, r};
    endfunction

    // compare one result with the oldest one due
    function void check_result(median_t median_x2, logic [COUNT_W-1:0] stored_count,
                               logic accepted);
      median_result_t r;
      if (due_q.size() == 0) begin
        $error("result with no request waiting: median_x2 %0d stored_count %0d",
               median_x2, stored_count);
        fail_count++;
        return;
      end
      r = due_q.pop_front();
      if (median_x2 !== r.median_x2) begin
        $error("median_x2: expected %0d, got %0d", r.median_x2, median_x2);
        fail_count++;
      end
      if (stored_count !== r.stored_count) begin
        $error("stored_count: expected %0d, got %0d", r.stored_count, stored_count);
        fail_count++;
      end
      if (accepted !== r.accepted) begin
        $error("accepted: expected %0d, got %0d", r.accepted, accepted);
        fail_count++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [SAMPLE_PORT_W-1:0] sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  median_t                  median_x2;
  logic [COUNT_W-1:0]       stored_count;
  logic                     accepted;

  median_scoreboard sb = new(CAPACITY);
  int               requests_sent = 0;

  sample_t directed_samples [22] = '{
    32'sd0, -32'sd1, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
    32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd5, 32'sd5, 32'sd5, -32'sd7,
    32'sd100, 32'sd200, 32'sd300, -32'sd100, -32'sd200, -32'sd300,
    32'sh5555_5555, 32'shAAAA_AAAA, 32'sd3, 32'sd3
  };

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  running_median_two_heap #(
    .CAPACITY     (CAPACITY),
    .SAMPLE_WIDTH (SAMPLE_PORT_W)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median_x2    (median_x2),
    .stored_count (stored_count),
    .accepted     (accepted)
  );

  // offer one request and hold it until taken
  task automatic send_sample(input sample_t value);
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (in_stall);
    sb.note_request(value);
    requests_sent++;
  endtask

  // gap between bursts
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // mix of wide, extreme, clustered and duplicate values
  function automatic sample_t random_sample();
    sample_t v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom();
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      3: v = $signed($urandom_range(0, 16)) - 32'sd8;
      4: v = 32'sh7FFF_FFFF - $signed($urandom_range(0, 3));
      5: v = 32'sh8000_0000 + $signed($urandom_range(0, 3));
      default: v = $signed($urandom_range(0, 2000)) - 32'sd1000;
    endcase
    return v;
  endfunction

  // stimulus, drain and verdict
  initial begin
    int burst_left;
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed requests, back to back
    foreach (directed_samples[k]) send_sample(directed_samples[k]);
    pause_sender($urandom_range(1, 10));

    // random requests in bursts
    burst_left = $urandom_range(1, 20);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      send_sample(random_sample());
      burst_left--;
      if (burst_left == 0 && i != RANDOM_ITEMS - 1) begin
        pause_sender($urandom_range(1, 20));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 20);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side stall pattern, with one long hold-off to back the block up
  initial begin
    int  mode;
    int  seg_len;
    int  k;
    bit  held_long;
    held_long = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held_long && requests_sent >= 60) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(20, 150);
      for (k = 0; k < seg_len; k++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((k % 7) < 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(median_x2, stored_count, accepted);
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rmth_pkg.sv
hdl/rmth_ram.sv
hdl/running_median_two_heap.sv
tb/sv/running_median_two_heap_tb.sv
